// ===== rtl/hfts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hfts_pkg;

    localparam int MAX_SIDE_DEF      = 256;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int COORD_W   = 24;
    localparam int POS_W     = 24;
    localparam int INDEX_W   = 16;
    localparam int SAMPLE_W  = 8;
    localparam int COUNT_W   = 9;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int HEIGHT_W  = 24;

    localparam int STORE_DEPTH = 1 << INDEX_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_SPACING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_SPACING    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH     = 3'd6;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // cell corners: A top-left, B right of A, C below A, D diagonal
    localparam logic [1:0] CORNER_A = 2'd0;
    localparam logic [1:0] CORNER_B = 2'd1;
    localparam logic [1:0] CORNER_C = 2'd2;
    localparam logic [1:0] CORNER_D = 2'd3;

    typedef struct packed {
        logic       store_wr;
        logic       ld_query;
        logic       div_start;
        logic       div_step;
        logic       range_chk;
        logic       fetch_rd;
        logic [1:0] rd_sel;
        logic       fetch_cap;
        logic [1:0] cap_sel;
        logic       mul1;
        logic       mul2;
        logic       sum;
        logic       scale;
        logic       emit;
        logic       emit_zero;
    } hfts_cmd_t;

    typedef struct packed {
        logic pos_neg;
        logic in_rng;
    } hfts_sts_t;

endpackage

`default_nettype wire

// ===== rtl/hfts_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface hfts_req_if;
    import hfts_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [INDEX_W-1:0]         sample_index;
    logic [SAMPLE_W-1:0]        sample_value;
    logic signed [COORD_W-1:0]  world_x;
    logic signed [COORD_W-1:0]  world_z;

    modport source (output valid, mode, sample_index, sample_value, world_x, world_z,
                    input ready);
    modport sink   (input valid, mode, sample_index, sample_value, world_x, world_z,
                    output ready);
endinterface

interface hfts_rsp_if;
    import hfts_pkg::*;

    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] height;
    logic                in_range;

    modport source (output valid, height, in_range, input ready);
    modport sink   (input valid, height, in_range, output ready);
endinterface

interface hfts_cfg_if;
    import hfts_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/hfts_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per step.
module hfts_div #(
    parameter int DVD_W = 40
) (
    input  wire logic                     clk,
    input  wire logic                     start,
    input  wire logic                     step,
    input  wire logic [DVD_W-1:0]         dividend,
    input  wire logic [hfts_pkg::CFG_W-1:0] divisor,
    output logic      [DVD_W-1:0]         quotient
);
    import hfts_pkg::*;

    logic [CFG_W-1:0] rem_reg;
    logic [CFG_W-1:0] rem_next;
    logic [DVD_W-1:0] quot_reg;
    logic [DVD_W-1:0] quot_next;
    logic [CFG_W:0]   trial;
    logic [CFG_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quot_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            rem_next  = '0;
            quot_next = dividend;
        end
        else if (step)
        begin
            rem_next  = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
            quot_next = {quot_reg[DVD_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ===== rtl/hfts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hfts_ctrl #(
    parameter int DVD_W = 40
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    input  wire logic                  req_mode,
    output logic                       req_ready,
    input  wire logic                  rsp_ready,
    output logic                       rsp_valid,
    input  wire hfts_pkg::hfts_sts_t   sts,
    output hfts_pkg::hfts_cmd_t        cmd
);
    import hfts_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_START = 4'd1;
    localparam logic [3:0] ST_DIV   = 4'd2;
    localparam logic [3:0] ST_CHECK = 4'd3;
    localparam logic [3:0] ST_FETCH = 4'd4;
    localparam logic [3:0] ST_MUL1  = 4'd5;
    localparam logic [3:0] ST_MUL2  = 4'd6;
    localparam logic [3:0] ST_SUM   = 4'd7;
    localparam logic [3:0] ST_SCALE = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    localparam logic [2:0] FETCH_FIRST = 3'd0;
    localparam logic [2:0] FETCH_LAST  = 3'd4;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       fetch_reg, fetch_next;
    logic [2:0]       fetch_prev;
    logic             zero_reg, zero_next;
    logic             out_valid_reg, out_valid_next;

    assign fetch_prev = fetch_reg - 3'd1;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        fetch_next     = fetch_reg;
        zero_next      = zero_reg;
        req_ready      = 1'b0;
        out_valid_next = out_valid_reg && !rsp_ready;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_mode == MODE_QUERY)
                    begin
                        cmd.ld_query = 1'b1;
                        zero_next    = 1'b0;
                        state_next   = ST_START;
                    end
                    else
                    begin
                        cmd.store_wr = 1'b1;
                    end
                end
            end
            ST_START:
            begin
                if (sts.pos_neg)
                begin
                    zero_next  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                    state_next = ST_CHECK;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_CHECK:
            begin
                cmd.range_chk = 1'b1;
                fetch_next    = FETCH_FIRST;
                state_next    = ST_FETCH;
            end
            ST_FETCH:
            begin
                if (!sts.in_rng)
                begin
                    zero_next  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    // read of corner k overlaps capture of corner k-1
                    if (fetch_reg != FETCH_LAST)
                    begin
                        cmd.fetch_rd = 1'b1;
                        cmd.rd_sel   = fetch_reg[1:0];
                    end
                    if (fetch_reg != FETCH_FIRST)
                    begin
                        cmd.fetch_cap = 1'b1;
                        cmd.cap_sel   = fetch_prev[1:0];
                    end
                    if (fetch_reg == FETCH_LAST)
                        state_next = ST_MUL1;
                    else
                        fetch_next = fetch_reg + 3'd1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_zero  = zero_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fetch_reg     <= FETCH_FIRST;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fetch_reg     <= fetch_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/hfts_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hfts_dp #(
    parameter int MAX_SIDE      = 256,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    hfts_req_if.sink                 req,
    hfts_rsp_if.source               rsp,
    hfts_cfg_if.sink                 cfg,
    input  wire hfts_pkg::hfts_cmd_t cmd,
    output hfts_pkg::hfts_sts_t      sts
);
    import hfts_pkg::*;

    localparam int FB    = FRACTION_BITS;
    localparam int DVD_W = POS_W + FB;
    localparam int W_W   = FB + 1;
    localparam int P_W   = FB + 11;
    localparam int RAW_W = FB + 12;
    localparam int RU_W  = FB + SAMPLE_W;
    localparam int PR_W  = RU_W + CFG_W;
    localparam logic [W_W-1:0] ONE = W_W'(1) << FB;
    localparam logic [COUNT_W-1:0] SIDE_CAP =
        (MAX_SIDE > (1 << COUNT_W) - 1) ? COUNT_W'((1 << COUNT_W) - 1) : COUNT_W'(MAX_SIDE);

    // configuration registers
    logic [COUNT_W-1:0] row_count_reg;
    logic [COUNT_W-1:0] column_count_reg;
    logic [CFG_W-1:0]   column_spacing_reg;
    logic [CFG_W-1:0]   row_spacing_reg;
    logic [CFG_W-1:0]   height_scale_reg;
    logic [CFG_W-1:0]   grid_width_reg;
    logic [CFG_W-1:0]   grid_depth_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg      <= COUNT_W'(256);
            column_count_reg   <= COUNT_W'(256);
            column_spacing_reg <= CFG_W'(256);
            row_spacing_reg    <= CFG_W'(256);
            height_scale_reg   <= CFG_W'(256);
            grid_width_reg     <= CFG_W'(255);
            grid_depth_reg     <= CFG_W'(255);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_ROW_COUNT:      row_count_reg      <= cfg.data[COUNT_W-1:0];
                CFG_COLUMN_COUNT:   column_count_reg   <= cfg.data[COUNT_W-1:0];
                CFG_COLUMN_SPACING: column_spacing_reg <= cfg.data;
                CFG_ROW_SPACING:    row_spacing_reg    <= cfg.data;
                CFG_HEIGHT_SCALE:   height_scale_reg   <= cfg.data;
                CFG_GRID_WIDTH:     grid_width_reg     <= cfg.data;
                CFG_GRID_DEPTH:     grid_depth_reg     <= cfg.data;
                default:            ;
            endcase
        end
    end

    logic [COUNT_W-1:0] rows_eff;
    logic [COUNT_W-1:0] cols_eff;
    logic [CFG_W-1:0]   cs_eff;
    logic [CFG_W-1:0]   rs_eff;

    assign rows_eff = (row_count_reg > SIDE_CAP) ? SIDE_CAP : row_count_reg;
    assign cols_eff = (column_count_reg > SIDE_CAP) ? SIDE_CAP : column_count_reg;
    assign cs_eff   = (column_spacing_reg == '0) ? CFG_W'(1) : column_spacing_reg;
    assign rs_eff   = (row_spacing_reg == '0) ? CFG_W'(1) : row_spacing_reg;

    // centered positions, 25-bit two's complement
    logic [POS_W:0] px_reg, px_next;
    logic [POS_W:0] pz_reg, pz_next;

    assign px_next = {req.world_x[COORD_W-1], req.world_x} + {2'b00, grid_width_reg, 7'd0};
    assign pz_next = {2'b00, grid_depth_reg, 7'd0} - {req.world_z[COORD_W-1], req.world_z};

    always_ff @(posedge clk)
    begin
        if (cmd.ld_query)
        begin
            px_reg <= px_next;
            pz_reg <= pz_next;
        end
    end

    assign sts.pos_neg = px_reg[POS_W] | pz_reg[POS_W];

    logic [DVD_W-1:0] qx;
    logic [DVD_W-1:0] qz;

    hfts_div #(.DVD_W(DVD_W)) u_div_x (
        .clk      (clk),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .dividend ({px_reg[POS_W-1:0], {FB{1'b0}}}),
        .divisor  (cs_eff),
        .quotient (qx)
    );

    hfts_div #(.DVD_W(DVD_W)) u_div_z (
        .clk      (clk),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .dividend ({pz_reg[POS_W-1:0], {FB{1'b0}}}),
        .divisor  (rs_eff),
        .quotient (qz)
    );

    logic [POS_W-1:0] ncol;
    logic [POS_W-1:0] nrow;
    logic [FB-1:0]    s_frac;
    logic [FB-1:0]    t_frac;

    assign ncol   = qx[DVD_W-1:FB];
    assign nrow   = qz[DVD_W-1:FB];
    assign s_frac = qx[FB-1:0];
    assign t_frac = qz[FB-1:0];

    // range check and cell base address
    logic                   in_rng_reg, in_rng_next;
    logic                   upper_reg, upper_next;
    logic [INDEX_W-1:0]     base_reg, base_next;
    logic [2*COUNT_W-1:0]   row_off;

    assign in_rng_next = ({1'b0, nrow} + (POS_W + 1)'(1) < (POS_W + 1)'(rows_eff))
                      && ({1'b0, ncol} + (POS_W + 1)'(1) < (POS_W + 1)'(cols_eff));
    assign row_off     = nrow[COUNT_W-1:0] * cols_eff;
    assign base_next   = row_off[INDEX_W-1:0] + INDEX_W'(ncol[COUNT_W-1:0]);
    assign upper_next  = ({1'b0, s_frac} + {1'b0, t_frac}) < ONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_rng_reg <= 1'b0;
        else if (cmd.range_chk)
            in_rng_reg <= in_rng_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.range_chk)
        begin
            upper_reg <= upper_next;
            base_reg  <= base_next;
        end
    end

    assign sts.in_rng = in_rng_reg;

    // sample store
    logic [SAMPLE_W-1:0] store_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;
    logic [INDEX_W-1:0]  rd_off;
    logic [INDEX_W-1:0]  rd_addr;

    always_comb
    begin
        case (cmd.rd_sel)
            CORNER_A: rd_off = '0;
            CORNER_B: rd_off = INDEX_W'(1);
            CORNER_C: rd_off = INDEX_W'(cols_eff);
            CORNER_D: rd_off = INDEX_W'(cols_eff) + INDEX_W'(1);
            default:  rd_off = '0;
        endcase
    end

    assign rd_addr = base_reg + rd_off;

    always_ff @(posedge clk)
    begin
        if (cmd.store_wr)
            store_mem[req.sample_index] <= req.sample_value;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch_rd)
            rdata_reg <= store_mem[rd_addr];
    end

    logic [SAMPLE_W-1:0] corner_reg [4];

    always_ff @(posedge clk)
    begin
        if (cmd.fetch_cap)
            corner_reg[cmd.cap_sel] <= rdata_reg;
    end

    // triangle interpolation
    logic [W_W-1:0]            w1, w2;
    logic signed [SAMPLE_W:0]  d1, d2;
    logic [SAMPLE_W-1:0]       anchor;
    logic signed [P_W-1:0]     p1_reg, p1_next;
    logic signed [P_W-1:0]     p2_reg, p2_next;
    logic signed [RAW_W-1:0]   raw_reg, raw_next;
    logic [RU_W-1:0]           rawu;
    logic [PR_W-1:0]           prod_reg, prod_next;

    always_comb
    begin
        if (upper_reg)
        begin
            anchor = corner_reg[CORNER_A];
            w1     = {1'b0, s_frac};
            w2     = {1'b0, t_frac};
            d1     = $signed({1'b0, corner_reg[CORNER_B]}) - $signed({1'b0, corner_reg[CORNER_A]});
            d2     = $signed({1'b0, corner_reg[CORNER_C]}) - $signed({1'b0, corner_reg[CORNER_A]});
        end
        else
        begin
            anchor = corner_reg[CORNER_D];
            w1     = ONE - {1'b0, s_frac};
            w2     = ONE - {1'b0, t_frac};
            d1     = $signed({1'b0, corner_reg[CORNER_C]}) - $signed({1'b0, corner_reg[CORNER_D]});
            d2     = $signed({1'b0, corner_reg[CORNER_B]}) - $signed({1'b0, corner_reg[CORNER_D]});
        end
    end

    assign p1_next   = $signed({1'b0, w1}) * d1;
    assign p2_next   = $signed({1'b0, w2}) * d2;
    assign raw_next  = $signed({4'b0000, anchor, {FB{1'b0}}}) + p1_reg + p2_reg;
    assign rawu      = raw_reg[RAW_W-1] ? '0 : raw_reg[RU_W-1:0];
    assign prod_next = rawu * height_scale_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
            p1_reg <= p1_next;
        if (cmd.mul2)
            p2_reg <= p2_next;
        if (cmd.sum)
            raw_reg <= raw_next;
        if (cmd.scale)
            prod_reg <= prod_next;
    end

    // result register
    logic [HEIGHT_W-1:0] height_reg;
    logic                in_range_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            height_reg   <= cmd.emit_zero ? '0 : prod_reg[FB +: HEIGHT_W];
            in_range_reg <= !cmd.emit_zero;
        end
    end

    assign rsp.height   = height_reg;
    assign rsp.in_range = in_range_reg;

endmodule

`default_nettype wire

// ===== rtl/heightfield_triangle_sampler.sv =====
// Heightfield triangle sampler.
// Channels: req (valid/ready) carries mode, sample_index, sample_value, world_x, world_z;
// rsp (valid/ready) carries height and in_range; cfg (valid/ready) writes register
// cfg.index with cfg.data. cfg.ready is always high; write only while the block is idle.
// A load (mode 0) writes one byte into the 64K-entry sample store and yields no result;
// loads are taken one per cycle while no query is in progress.
// A query (mode 1) yields one result. A query that clears the sign check runs two
// restoring dividers side by side, one quotient bit per cycle; this loop sets the query
// time. Then a range check, the reads of the four corners on the single store read port,
// the two weighted products, a sum, the height scaling and the result write. A cell
// outside the grid skips the corner reads and the arithmetic, and a negative centered
// position skips the dividers as well. req.ready comes back in the same cycle that
// rsp.valid rises.
// The result sits in an output register: the next item is accepted while it waits.
// If rsp stalls with a result still held, a finished query waits in its last step.
// Reset clears the control and the configuration registers to their defaults; the store
// contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module heightfield_triangle_sampler #(
    parameter int MAX_SIDE      = hfts_pkg::MAX_SIDE_DEF,
    parameter int FRACTION_BITS = hfts_pkg::FRACTION_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hfts_req_if.sink   req,
    hfts_rsp_if.source rsp,
    hfts_cfg_if.sink   cfg
);
    import hfts_pkg::*;

    localparam int DVD_W = POS_W + FRACTION_BITS;

    hfts_cmd_t cmd;
    hfts_sts_t sts;
    logic      req_ready;
    logic      rsp_valid;

    hfts_ctrl #(.DVD_W(DVD_W)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_mode  (req.mode),
        .req_ready (req_ready),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    hfts_dp #(
        .MAX_SIDE      (MAX_SIDE),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;

endmodule

`default_nettype wire

// ===== rtl/hfts_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hfts_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          req_mode,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [hfts_pkg::HEIGHT_W-1:0] rsp_height,
    input wire logic                          rsp_in_range
);
    import hfts_pkg::*;

    // held result stays put until its transaction completes
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_height) && $stable(rsp_in_range))
        else $error("rsp payload changed while stalled");

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_in_range |-> rsp_height == '0)
        else $error("out-of-range result with nonzero height");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_mode == MODE_QUERY |=> !req_ready)
        else $error("request taken while a query is in progress");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_mode == MODE_LOAD |=> !$rose(rsp_valid))
        else $error("load produced a result");

endmodule

bind heightfield_triangle_sampler hfts_checker u_hfts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_mode     (req.mode),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_height   (rsp.height),
    .rsp_in_range (rsp.in_range)
);

`default_nettype wire

// ===== verif/tb_heightfield_triangle_sampler.sv =====
`timescale 1ns / 1ps

module tb_heightfield_triangle_sampler;
    import hfts_pkg::*;

    localparam int     FRAC     = FRACTION_BITS_DEF;
    localparam longint FRAC_ONE = longint'(1) << FRAC;
    // world position of the grid corner at column 0, row 0 with the reset configuration
    localparam int     X0       = -32640;
    localparam int     Z0       = 32640;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic                in_range;
    } height_result_t;

    typedef enum int {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    // Mirrors the configuration and the sample store, predicts one result per query.
    class height_checker_t;
        bit [COUNT_W-1:0]  row_count      = 256;
        bit [COUNT_W-1:0]  column_count   = 256;
        bit [CFG_W-1:0]    column_spacing = 256;
        bit [CFG_W-1:0]    row_spacing    = 256;
        bit [CFG_W-1:0]    height_scale   = 256;
        bit [CFG_W-1:0]    grid_width     = 255;
        bit [CFG_W-1:0]    grid_depth     = 255;
        bit [SAMPLE_W-1:0] samples [STORE_DEPTH];
        height_result_t    pending_heights [$];
        int                errors;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_ROW_COUNT:      row_count      = data[COUNT_W-1:0];
                CFG_COLUMN_COUNT:   column_count   = data[COUNT_W-1:0];
                CFG_COLUMN_SPACING: column_spacing = data;
                CFG_ROW_SPACING:    row_spacing    = data;
                CFG_HEIGHT_SCALE:   height_scale   = data;
                CFG_GRID_WIDTH:     grid_width     = data;
                CFG_GRID_DEPTH:     grid_depth     = data;
                default: ;
            endcase
        endfunction

        function int unsigned rows_in_use();
            return (row_count > MAX_SIDE_DEF) ? MAX_SIDE_DEF : row_count;
        endfunction

        function int unsigned cols_in_use();
            return (column_count > MAX_SIDE_DEF) ? MAX_SIDE_DEF : column_count;
        endfunction

        // Returns 1 when the whole cell is inside the grid; corners come out as A, B, C, D.
        function bit locate(input logic signed [COORD_W-1:0] x, z,
                            output logic [3:0][INDEX_W-1:0] corners,
                            output longint s, t);
            longint px, pz, cs, rs, colq, rowq, ncol, nrow, cols, base;
            corners = '0;
            s = 0;
            t = 0;
            px = longint'(x) + longint'(grid_width) * 128;
            pz = longint'(grid_depth) * 128 - longint'(z);
            if (px < 0 || pz < 0)
                return 1'b0;
            cs = (column_spacing == 0) ? 1 : longint'(column_spacing);
            rs = (row_spacing == 0) ? 1 : longint'(row_spacing);
            colq = (px * FRAC_ONE) / cs;
            rowq = (pz * FRAC_ONE) / rs;
            ncol = colq >> FRAC;
            nrow = rowq >> FRAC;
            s = colq & (FRAC_ONE - 1);
            t = rowq & (FRAC_ONE - 1);
            cols = longint'(cols_in_use());
            if (!(nrow + 1 < longint'(rows_in_use()) && ncol + 1 < cols))
                return 1'b0;
            base = nrow * cols + ncol;
            corners[0] = base[INDEX_W-1:0];
            corners[1] = INDEX_W'(base + 1);
            corners[2] = INDEX_W'(base + cols);
            corners[3] = INDEX_W'(base + cols + 1);
            return 1'b1;
        endfunction

        function void note_item(logic mode, logic [INDEX_W-1:0] idx, logic [SAMPLE_W-1:0] val,
                                logic signed [COORD_W-1:0] x, z);
            logic [3:0][INDEX_W-1:0] corners;
            longint s, t, a, b, c, d, raw, h;
            height_result_t res;
            if (mode == MODE_LOAD)
            begin
                samples[idx] = val;
                return;
            end
            res = '0;
            if (locate(x, z, corners, s, t))
            begin
                a = longint'(samples[corners[0]]);
                b = longint'(samples[corners[1]]);
                c = longint'(samples[corners[2]]);
                d = longint'(samples[corners[3]]);
                if (s + t < FRAC_ONE)
                    raw = a * FRAC_ONE + s * (b - a) + t * (c - a);
                else
                    raw = d * FRAC_ONE + (FRAC_ONE - s) * (c - d) + (FRAC_ONE - t) * (b - d);
                if (raw < 0)
                    raw = 0;
                h = (raw * longint'(height_scale)) >> FRAC;
                res.height   = h[HEIGHT_W-1:0];
                res.in_range = 1'b1;
            end
            pending_heights = {pending_heights, res};
        endfunction

        function void check_result(logic [HEIGHT_W-1:0] height, logic in_range);
            height_result_t exp_res;
            if (pending_heights.size() == 0)
            begin
                $display("%0t: result with nothing pending: height %h in_range %b",
                         $time, height, in_range);
                errors++;
                return;
            end
            exp_res = pending_heights.pop_front();
            if (height !== exp_res.height)
            begin
                $display("%0t: height mismatch: expected %h, got %h", $time,
                         exp_res.height, height);
                errors++;
            end
            if (in_range !== exp_res.in_range)
            begin
                $display("%0t: in_range mismatch: expected %b, got %b", $time,
                         exp_res.in_range, in_range);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    hfts_req_if req_ch ();
    hfts_rsp_if rsp_ch ();
    hfts_cfg_if cfg_ch ();

    heightfield_triangle_sampler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    height_checker_t sb;
    bit              loaded [STORE_DEPTH];
    int              src_idle_pct;
    int              snk_stall_pct;
    bit              hold_request;
    int              phase_no;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    initial
    begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls plus an occasional long hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left = 400;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.height, rsp_ch.in_range);
    end

    task automatic set_idling(idle_mode_t m);
        case (m)
            IDLE_NONE:
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            IDLE_SOURCE:
            begin
                src_idle_pct  = 62;
                snk_stall_pct = 0;
            end
            IDLE_SINK:
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 62;
            end
            default:
            begin
                src_idle_pct  = 34;
                snk_stall_pct = 34;
            end
        endcase
    endtask

    // entered and left at a falling edge
    task automatic send_item(logic mode, logic [INDEX_W-1:0] idx, logic [SAMPLE_W-1:0] val,
                             logic signed [COORD_W-1:0] x, z);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= mode;
        req_ch.sample_index <= idx;
        req_ch.sample_value <= val;
        req_ch.world_x      <= x;
        req_ch.world_z      <= z;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_item(mode, idx, val, x, z);
        @(negedge clk);
    endtask

    task automatic send_load(logic [INDEX_W-1:0] idx, logic [SAMPLE_W-1:0] val);
        loaded[idx] = 1'b1;
        send_item(MODE_LOAD, idx, val, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // corners of an in-range cell are loaded first so no unwritten sample is ever read
    task automatic send_query(logic signed [COORD_W-1:0] x, z);
        logic [3:0][INDEX_W-1:0] corners;
        longint s, t;
        if (sb.locate(x, z, corners, s, t))
        begin
            for (int k = 0; k < 4; k++)
                if (!loaded[corners[k]] || $urandom_range(0, 5) == 0)
                    send_load(corners[k], SAMPLE_W'($urandom));
        end
        send_item(MODE_QUERY, INDEX_W'($urandom), SAMPLE_W'($urandom), x, z);
    endtask

    function automatic longint offset_in_cell(longint span);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return span - 1;
            default: return longint'($urandom_range(0, int'(span - 1)));
        endcase
    endfunction

    // world position inside a random cell; near_edge pushes it one cell past the far edge
    function automatic void pick_query(input bit near_edge,
                                       output logic signed [COORD_W-1:0] x, z);
        longint rows, cols, cs, rs, ncol, nrow, wx, wz, half_w, half_d;
        rows = longint'(sb.rows_in_use());
        cols = longint'(sb.cols_in_use());
        if (rows < 2 || cols < 2)
        begin
            x = COORD_W'($urandom);
            z = COORD_W'($urandom);
            return;
        end
        cs = (sb.column_spacing == 0) ? 1 : longint'(sb.column_spacing);
        rs = (sb.row_spacing == 0) ? 1 : longint'(sb.row_spacing);
        half_w = longint'(sb.grid_width) * 128;
        half_d = longint'(sb.grid_depth) * 128;
        ncol = longint'($urandom_range(0, int'(cols - 2)));
        nrow = longint'($urandom_range(0, int'(rows - 2)));
        if (near_edge)
        begin
            if ($urandom_range(0, 1))
                ncol = cols - 1;
            else
                nrow = rows - 1;
        end
        wx = ncol * cs + offset_in_cell(cs) - half_w;
        if (wx > 8388607)
            wx = offset_in_cell(cs) - half_w;
        wz = half_d - (nrow * rs + offset_in_cell(rs));
        if (wz < -8388608)
            wz = half_d - offset_in_cell(rs);
        x = wx[COORD_W-1:0];
        z = wz[COORD_W-1:0];
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (sb.pending_heights.size() != 0)
            @(posedge clk);
        // a trailing load may still be in flight
        repeat (70) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_config(int rows, int cols, int cs, int rs, int scale, int gw, int gd);
        req_ch.valid <= 1'b0;
        wait_drained();
        write_reg(CFG_ROW_COUNT, CFG_W'(rows));
        write_reg(CFG_COLUMN_COUNT, CFG_W'(cols));
        write_reg(CFG_COLUMN_SPACING, CFG_W'(cs));
        write_reg(CFG_ROW_SPACING, CFG_W'(rs));
        write_reg(CFG_HEIGHT_SCALE, CFG_W'(scale));
        write_reg(CFG_GRID_WIDTH, CFG_W'(gw));
        write_reg(CFG_GRID_DEPTH, CFG_W'(gd));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_items(int n, int hold_at);
        logic signed [COORD_W-1:0] x, z;
        int roll;
        for (int i = 0; i < n; i++)
        begin
            set_idling(idle_mode_t'((phase_no + i / 12) % 4));
            if (i == hold_at)
                hold_request = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 65)
            begin
                pick_query(1'b0, x, z);
                send_query(x, z);
            end
            else if (roll < 75)
            begin
                send_load(INDEX_W'($urandom), SAMPLE_W'($urandom));
            end
            else if (roll < 85)
            begin
                send_query(COORD_W'($urandom), COORD_W'($urandom));
            end
            else
            begin
                pick_query(1'b1, x, z);
                send_query(x, z);
            end
        end
        phase_no++;
    endtask

    // reset configuration: cell (0,0) spans 256 world units on each axis from (X0, Z0)
    task automatic directed_items();
        set_idling(IDLE_NONE);
        send_load(16'd0, 8'd10);
        send_load(16'd1, 8'd250);
        send_load(16'd256, 8'd0);
        send_load(16'd257, 8'd255);
        send_load(16'hFFFF, 8'hFF);
        send_load(16'h5555, 8'h55);
        send_load(16'hAAAA, 8'hAA);
        send_query(COORD_W'(X0), COORD_W'(Z0));
        send_query(COORD_W'(X0 + 255), COORD_W'(Z0));
        send_query(COORD_W'(X0), COORD_W'(Z0 - 255));
        // s + t exactly one: lower triangle
        send_query(COORD_W'(X0 + 128), COORD_W'(Z0 - 128));
        send_query(COORD_W'(X0 + 200), COORD_W'(Z0 - 100));
        send_query(COORD_W'(X0 + 100), COORD_W'(Z0 - 27));
        send_query(COORD_W'(X0 - 1), COORD_W'(Z0));             // negative centered x
        send_query(COORD_W'(X0), COORD_W'(Z0 + 1));             // negative centered z
        send_query(COORD_W'(-8388608), COORD_W'(8388607));
        send_query(COORD_W'(8388607), COORD_W'(-8388608));
        send_query(COORD_W'(32384 + 17), COORD_W'(-32384 - 5)); // last full cell
        send_query(COORD_W'(32640), COORD_W'(0));               // column past the last full cell
        send_query(COORD_W'(0), COORD_W'(-32640));              // row past the last full cell
    endtask

    initial
    begin
        sb = new;
        phase_no      = 0;
        hold_request  = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        rst_n = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.mode         = MODE_LOAD;
        req_ch.sample_index = '0;
        req_ch.sample_value = '0;
        req_ch.world_x      = '0;
        req_ch.world_z      = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_ROW_COUNT;
        cfg_ch.data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_items();
        random_items(40, 6);

        apply_config(4, 5, 16'h0180, 16'h0200, 16'h0180, 6, 6);
        random_items(45, -1);
        // minimum counts, zero spacings, full scale
        apply_config(2, 2, 0, 0, 65535, 0, 0);
        random_items(35, -1);
        // counts above the maximum side, widest spacing and extent, zero scale
        apply_config(511, 300, 65535, 65535, 0, 65535, 65535);
        random_items(45, -1);
        // counts too small for any cell
        apply_config(1, 0, 256, 256, 256, 255, 255);
        random_items(15, -1);
        apply_config(256, 256, 16'h0040, 16'h0333, 16'h1234, 40000, 1234);
        random_items(45, -1);
        repeat (2)
        begin
            apply_config($urandom_range(2, 300), $urandom_range(2, 300),
                         $urandom_range(1, 65535), $urandom_range(1, 65535),
                         $urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 65535));
            random_items(35, -1);
        end

        req_ch.valid <= 1'b0;
        while (sb.pending_heights.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (sb.errors == 0 && sb.pending_heights.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
